// ===== rtl/lmtr_pkg.sv =====
// Shared types and constants for the LCD mode timing and register block.
`timescale 1ns / 1ps

package lmtr_pkg;

   // Command codes carried in the request tuser
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // Register indexes
   localparam logic [3:0] REG_LCDC = 4'd0;
   localparam logic [3:0] REG_STAT = 4'd1;
   localparam logic [3:0] REG_LY   = 4'd4;
   localparam logic [3:0] REG_LYC  = 4'd5;
   localparam logic [3:0] REG_DMA  = 4'd6;
   localparam int unsigned NUM_REGS = 12;
   localparam logic [3:0] REG_COUNT = 4'(NUM_REGS);

   // Status mode codes
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Mode lengths in cycles
   localparam logic [15:0] CYC_OAM         = 16'd80;
   localparam logic [15:0] CYC_XFER        = 16'd172;
   localparam logic [15:0] CYC_XFER_RENDER = 16'd160;
   localparam logic [15:0] CYC_HBLANK      = 16'd204;
   localparam logic [15:0] CYC_VBLANK      = 16'd4560;
   localparam logic [7:0]  VBLANK_LINE     = 8'd144;

   // Control and status bit positions
   localparam int unsigned LCDC_ENABLE_BIT = 7;
   localparam int unsigned STAT_COINC_BIT  = 2;
   localparam int unsigned STAT_HBL_IE_BIT = 3;
   localparam int unsigned STAT_VBL_IE_BIT = 4;
   localparam int unsigned STAT_OAM_IE_BIT = 5;
   localparam int unsigned STAT_LYC_IE_BIT = 6;
   localparam logic [7:0]  STAT_READ_SET   = 8'b1000_0000;
   localparam logic [7:0]  OPEN_BUS        = 8'hFF;

   // Current state seen by the step logic
   typedef struct packed {
      logic [7:0]  lcdc;
      logic [7:0]  stat;
      logic [7:0]  ly;
      logic [7:0]  lyc;
      logic [15:0] cycle;
      logic        rendered;
   } view_type;

   // State update issued by the step logic
   typedef struct packed {
      logic        en;
      logic        bus_we;
      logic [3:0]  bus_idx;
      logic [7:0]  bus_data;
      logic        tim_we;
      logic [7:0]  ly;
      logic [7:0]  stat;
      logic [15:0] cycle;
      logic        rendered;
   } upd_type;

   // One result beat
   typedef struct packed {
      logic [7:0] dma_page;
      logic       dma_start;
      logic       frame_ready;
      logic       line_ready;
      logic       stat_irq;
      logic       vblank_irq;
      logic [7:0] read_data;
   } result_type;

endpackage

// ===== rtl/lcd_mode_timing_registers_unit.sv =====
// Top level of the LCD mode timing and register block.
`timescale 1ns / 1ps

// LCD controller timing and register file.
// Request channel (req_*): one beat per command. tuser carries the command
// (tick, register read, register write); tdata carries the register index,
// the write byte and the tick length in cycles.
// Response channel (rsp_*): exactly one beat per request, in order, with the
// read byte, the VBlank and status interrupt requests, the scanline and
// frame strobes and the DMA start strobe with its source page.
// A request sits in an input register, the step logic updates the register
// file and timing counter and fills the output register in the same cycle,
// so a response passes the input register and then the output register. One
// request per cycle is sustained while rsp_tready stays high; the only path is
// the single combinational step between the input and output registers.
// Reset clears all twelve registers, the cycle counter and the render flag
// at once and empties both stages. When the receiver stalls, the output
// register holds its beat and the input register takes one more request,
// after which req_tready drops until the response is taken.
module lcd_mode_timing_registers_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // reg_index[3:0], write_data[11:4], delta[19:12], zero
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_data[7:0], vblank_irq[8], stat_irq[9],
                                    // line_ready[10], frame_ready[11], dma_start[12],
                                    // dma_page[20:13], zero
);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_cmd_ff;
   logic [3:0]  s1_idx_ff;
   logic [7:0]  s1_wdata_ff;
   logic [7:0]  s1_delta_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        req_fire;
   logic        s1_adv;

   lmtr_pkg::view_type   view;
   lmtr_pkg::upd_type    upd;
   lmtr_pkg::result_type res;
   logic [7:0]           rd_byte;

   // Handshake: the input stage moves on when the output register is free
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req_tuser;
         s1_idx_ff   <= req_tdata[3:0];
         s1_wdata_ff <= req_tdata[11:4];
         s1_delta_ff <= req_tdata[19:12];
      end
   end

   // Register file and timing state
   lmtr_state u_state (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .rd_idx  (s1_idx_ff),
      .rd_byte (rd_byte),
      .view    (view)
   );

   // Step logic for the beat in the input register
   lmtr_step u_step (
      .en         (s1_adv),
      .cmd        (s1_cmd_ff),
      .reg_index  (s1_idx_ff),
      .write_data (s1_wdata_ff),
      .delta      (s1_delta_ff),
      .view       (view),
      .rd_byte    (rd_byte),
      .upd        (upd),
      .res        (res)
   );

   // Output register
   assign rsp_data_in = {3'b000, res};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/lmtr_state.sv =====
// Register file, cycle counter and render flag of the LCD timing block.
`timescale 1ns / 1ps

module lmtr_state (
   input  logic              clock,
   input  logic              reset,
   input  lmtr_pkg::upd_type upd,
   input  logic [3:0]        rd_idx,
   output logic [7:0]        rd_byte,
   output lmtr_pkg::view_type view
);

   logic [7:0]  regs_ff [lmtr_pkg::NUM_REGS];
   logic [15:0] cycle_ff;
   logic        rendered_ff;

   // Apply the bus write and the timing update of the beat in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lmtr_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= 8'h00;
         end
         cycle_ff    <= 16'h0000;
         rendered_ff <= 1'b0;
      end else if (upd.en) begin
         if (upd.bus_we) begin
            regs_ff[upd.bus_idx] <= upd.bus_data;
         end
         if (upd.tim_we) begin
            regs_ff[lmtr_pkg::REG_LY]   <= upd.ly;
            regs_ff[lmtr_pkg::REG_STAT] <= upd.stat;
            cycle_ff                    <= upd.cycle;
            rendered_ff                 <= upd.rendered;
         end
      end
   end

   // Bus read: status top bit reads set, open bus past the last register
   always_comb begin
      if (rd_idx < lmtr_pkg::REG_COUNT) begin
         rd_byte = regs_ff[rd_idx];
         if (rd_idx == lmtr_pkg::REG_STAT) begin
            rd_byte = rd_byte | lmtr_pkg::STAT_READ_SET;
         end
      end else begin
         rd_byte = lmtr_pkg::OPEN_BUS;
      end
   end

   assign view.lcdc     = regs_ff[lmtr_pkg::REG_LCDC];
   assign view.stat     = regs_ff[lmtr_pkg::REG_STAT];
   assign view.ly       = regs_ff[lmtr_pkg::REG_LY];
   assign view.lyc      = regs_ff[lmtr_pkg::REG_LYC];
   assign view.cycle    = cycle_ff;
   assign view.rendered = rendered_ff;

endmodule

// ===== rtl/lmtr_step.sv =====
// Per-beat logic: mode sequencing on ticks, bus read and write decode.
`timescale 1ns / 1ps

module lmtr_step (
   input  logic                  en,
   input  logic [1:0]            cmd,
   input  logic [3:0]            reg_index,
   input  logic [7:0]            write_data,
   input  logic [7:0]            delta,
   input  lmtr_pkg::view_type    view,
   input  logic [7:0]            rd_byte,
   output lmtr_pkg::upd_type     upd,
   output lmtr_pkg::result_type  res
);

   logic [16:0] sum;
   logic [15:0] cyc;
   logic [7:0]  ly_inc;
   logic        ly_match;
   logic [7:0]  stat_c;
   logic        is_tick;
   logic        is_write;

   assign is_tick  = (cmd == lmtr_pkg::CMD_TICK);
   assign is_write = (cmd == lmtr_pkg::CMD_WRITE);

   // Saturating cycle accumulate
   assign sum = {1'b0, view.cycle} + {9'd0, delta};
   assign cyc = sum[16] ? 16'hFFFF : sum[15:0];

   // Next line at the end of HBlank and its coincidence flag
   assign ly_inc   = view.ly + 8'd1;
   assign ly_match = (ly_inc == view.lyc);
   always_comb begin
      stat_c = view.stat;
      stat_c[lmtr_pkg::STAT_COINC_BIT] = ly_match;
   end

   // Bus write: line register and out-of-range indexes are dropped
   always_comb begin
      upd.en       = en;
      upd.bus_we   = is_write && (reg_index < lmtr_pkg::REG_COUNT)
                     && (reg_index != lmtr_pkg::REG_LY);
      upd.bus_idx  = reg_index;
      upd.bus_data = write_data;
   end

   // Mode timing on a tick
   always_comb begin
      upd.tim_we      = is_tick;
      upd.ly          = view.ly;
      upd.stat        = view.stat;
      upd.cycle       = cyc;
      upd.rendered    = view.rendered;
      res.vblank_irq  = 1'b0;
      res.stat_irq    = 1'b0;
      res.line_ready  = 1'b0;
      res.frame_ready = 1'b0;

      if (!view.lcdc[lmtr_pkg::LCDC_ENABLE_BIT]) begin
         // display off: hold at line 0, HBlank, counter clear
         upd.ly    = 8'd0;
         upd.stat  = {view.stat[7:2], lmtr_pkg::MODE_HBLANK};
         upd.cycle = 16'd0;
      end else begin
         case (view.stat[1:0])
            lmtr_pkg::MODE_HBLANK: begin
               if (cyc >= lmtr_pkg::CYC_HBLANK) begin
                  upd.cycle = cyc - lmtr_pkg::CYC_HBLANK;
                  upd.ly    = ly_inc;
                  if (ly_inc == lmtr_pkg::VBLANK_LINE) begin
                     res.frame_ready = 1'b1;
                     res.vblank_irq  = 1'b1;
                     res.stat_irq    = stat_c[lmtr_pkg::STAT_VBL_IE_BIT];
                     upd.stat        = {stat_c[7:2], lmtr_pkg::MODE_VBLANK};
                  end else begin
                     res.stat_irq = stat_c[lmtr_pkg::STAT_OAM_IE_BIT]
                                    | (stat_c[lmtr_pkg::STAT_LYC_IE_BIT] & ly_match);
                     upd.stat     = {stat_c[7:2], lmtr_pkg::MODE_OAM};
                  end
               end
            end
            lmtr_pkg::MODE_VBLANK: begin
               if (cyc >= lmtr_pkg::CYC_VBLANK) begin
                  // back to the top line, coincidence against line 0
                  upd.cycle = cyc - lmtr_pkg::CYC_VBLANK;
                  upd.ly    = 8'd0;
                  upd.stat  = {view.stat[7:3], (view.lyc == 8'd0), lmtr_pkg::MODE_OAM};
               end
            end
            lmtr_pkg::MODE_OAM: begin
               if (cyc >= lmtr_pkg::CYC_OAM) begin
                  upd.cycle    = cyc - lmtr_pkg::CYC_OAM;
                  upd.rendered = 1'b0;
                  upd.stat     = {view.stat[7:2], lmtr_pkg::MODE_XFER};
               end
            end
            lmtr_pkg::MODE_XFER: begin
               if ((cyc >= lmtr_pkg::CYC_XFER_RENDER) && !view.rendered) begin
                  res.line_ready = 1'b1;
                  upd.rendered   = 1'b1;
               end
               if (cyc >= lmtr_pkg::CYC_XFER) begin
                  upd.cycle    = cyc - lmtr_pkg::CYC_XFER;
                  upd.stat     = {view.stat[7:2], lmtr_pkg::MODE_HBLANK};
                  res.stat_irq = view.stat[lmtr_pkg::STAT_HBL_IE_BIT];
               end
            end
            default: begin
               upd.stat = view.stat;
            end
         endcase
      end

      if (!is_tick) begin
         res.vblank_irq  = 1'b0;
         res.stat_irq    = 1'b0;
         res.line_ready  = 1'b0;
         res.frame_ready = 1'b0;
      end
   end

   // Read data and DMA strobe
   always_comb begin
      res.read_data = (cmd == lmtr_pkg::CMD_READ) ? rd_byte : 8'h00;
      res.dma_start = is_write && (reg_index == lmtr_pkg::REG_DMA);
      res.dma_page  = res.dma_start ? write_data : 8'h00;
   end

endmodule
